### src/flha_pkg.sv
// Shared types and constants for the free-list heap allocator.
// Used by the controller, the datapath and the top level.
package flha_pkg;
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BIG  = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_PLACE  = 3'd1;
  localparam logic [2:0] CMD_ALLOC  = 3'd2;
  localparam logic [2:0] CMD_GROW   = 3'd3;

  typedef struct packed {
    logic [2:0] cmd;
    logic       go;
  } flha_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [1:0] status;
  } flha_stat_t;
endpackage

### src/flha_datapath.sv
// Free table datapath: table memory, place/remove sweeps, size-order search, heap growth.
// Depends on flha_pkg; driven by flha_ctrl through command and status structs.
module flha_datapath #(
  parameter int HEAP_BYTES      = 65536,
  parameter int CHUNK_BYTES     = 8192,
  parameter int HEADER_BYTES    = 32,
  parameter int MIN_SPLIT_BYTES = 40,
  parameter int FREE_SLOTS      = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  flha_pkg::flha_cmd_t cmd,
  input  logic [15:0]         arg_start,
  input  logic [16:0]         arg_size,
  input  logic [16:0]         arg_actual,
  output flha_pkg::flha_stat_t stat,
  output logic [15:0]         addr
);
  import flha_pkg::*;
  localparam int IW = $clog2(FREE_SLOTS);
  localparam int CW = $clog2(FREE_SLOTS + 1);

  localparam logic [4:0] S_IDLE = 5'd0,  S_PSCAN = 5'd1,  S_PDEC = 5'd2,  S_PSHR = 5'd3,
                         S_RMV = 5'd4,  S_SRCH = 5'd5,  S_SEVAL = 5'd6, S_DONE = 5'd7,
                         S_PRD = 5'd8,  S_PRD2 = 5'd9,  S_PWR = 5'd10, S_SRD = 5'd11,
                         S_SHRD = 5'd12, S_RMRD = 5'd13, S_PLW = 5'd14;

  logic [15:0] mst [FREE_SLOTS];
  logic [16:0] msz [FREE_SLOTS];
  logic [IW-1:0] ra_a;
  logic [15:0] rd_st;
  logic [16:0] rd_sz;
  logic        we;
  logic [IW-1:0] wa;
  logic [15:0] wst;
  logic [16:0] wsz;

  always_ff @(posedge clk) begin
    if (we) begin
      mst[wa] <= wst;
      msz[wa] <= wsz;
    end
    rd_st <= mst[ra_a];
    rd_sz <= msz[ra_a];
  end

  logic [4:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [16:0]   brk_r, brk_nxt;
  logic [CW-1:0] p_r, p_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [15:0]   st_r, st_nxt;
  logic [16:0]   sz_r, sz_nxt;
  logic [15:0]   lst_r, lst_nxt;
  logic [16:0]   lsz_r, lsz_nxt;
  logic          alloc_r, alloc_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [16:0]   csz_r, csz_nxt;
  logic [15:0]   cst_r, cst_nxt;
  logic          hascur_r, hascur_nxt;
  logic [CW-1:0] best_r, best_nxt;
  logic [16:0]   bsz_r, bsz_nxt;
  logic [15:0]   bst_r, bst_nxt;
  logic          hasb_r, hasb_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [15:0]   addr_r, addr_nxt;

  logic cand_ok, cand_better;
  always_comb begin
    cand_ok = !hascur_r || (rd_sz > csz_r) || (rd_sz == csz_r && rd_st > cst_r) ||
              (rd_sz == csz_r && rd_st == cst_r && (k_r - 1'b1) > cur_r);
    cand_better = !hasb_r || (rd_sz < bsz_r) || (rd_sz == bsz_r && rd_st < bst_r);
  end

  logic [17:0] grow_end;
  assign grow_end = {1'b0, brk_r} + 18'(CHUNK_BYTES);

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; brk_nxt = brk_r;
    p_nxt = p_r; k_nxt = k_r; st_nxt = st_r; sz_nxt = sz_r;
    lst_nxt = lst_r; lsz_nxt = lsz_r; alloc_nxt = alloc_r;
    cur_nxt = cur_r; csz_nxt = csz_r; cst_nxt = cst_r; hascur_nxt = hascur_r;
    best_nxt = best_r; bsz_nxt = bsz_r; bst_nxt = bst_r; hasb_nxt = hasb_r;
    status_nxt = status_r; addr_nxt = addr_r;
    ra_a = IW'(k_r); we = 1'b0; wa = IW'(p_r); wst = st_r; wsz = sz_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.go) begin
          status_nxt = ST_OK; addr_nxt = '0; hascur_nxt = 1'b0;
          unique case (cmd.cmd)
            CMD_PLACE: begin
              st_nxt = arg_start; sz_nxt = arg_size; alloc_nxt = 1'b0;
              p_nxt = '0; k_nxt = '0; state_nxt = S_PRD;
            end
            CMD_ALLOC, CMD_GROW: begin
              alloc_nxt = 1'b1;
              if (count_r == '0 || cmd.cmd == CMD_GROW) begin
                state_nxt = S_DONE;
                if (grow_end > 18'(HEAP_BYTES)) status_nxt = ST_OOM;
                else begin
                  st_nxt = brk_r[15:0]; sz_nxt = 17'(CHUNK_BYTES);
                  p_nxt = '0; k_nxt = '0; state_nxt = S_PRD;
                end
              end else begin
                k_nxt = '0; hasb_nxt = 1'b0; state_nxt = S_SRD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_PRD: begin
        ra_a = IW'(p_r);
        if (p_r < count_r) state_nxt = S_PSCAN; else state_nxt = S_PDEC;
      end
      S_PSCAN: begin
        ra_a = IW'(p_r);
        if (rd_st < st_r) begin
          lst_nxt = rd_st; lsz_nxt = rd_sz; p_nxt = p_r + 1'b1;
          ra_a = IW'(p_r + 1'b1);
          if (p_r + 1'b1 >= count_r) state_nxt = S_PDEC;
        end else state_nxt = S_PDEC;
      end
      S_PDEC: begin
        logic lft, rgt;
        logic [16:0] ls;
        lft = (p_r != '0) && ({2'b0, lst_r} + {1'b0, lsz_r} == {2'b0, st_r});
        rgt = (p_r < count_r) && (17'(st_r) + sz_r == {1'b0, rd_st});
        ls = lsz_r + sz_r;
        state_nxt = S_PLW;
        if (lft && rgt) begin
          we = 1'b1; wa = IW'(p_r - 1'b1); wst = lst_r; wsz = ls + rd_sz;
          cur_nxt = p_r - 1'b1; k_nxt = p_r; state_nxt = S_RMRD;
        end else if (lft) begin
          we = 1'b1; wa = IW'(p_r - 1'b1); wst = lst_r; wsz = ls; cur_nxt = p_r - 1'b1;
        end else if (rgt) begin
          we = 1'b1; wst = st_r; wsz = rd_sz + sz_r; cur_nxt = p_r;
        end else if (count_r >= CW'(FREE_SLOTS)) begin
          status_nxt = ST_FULL; state_nxt = S_DONE;
        end else begin
          cur_nxt = p_r; k_nxt = count_r; state_nxt = S_SHRD;
        end
      end
      S_SHRD: begin
        ra_a = IW'(k_r - 1'b1);
        if (k_r == p_r) begin
          we = 1'b1; wst = st_r; wsz = sz_r; count_nxt = count_r + 1'b1; state_nxt = S_PLW;
        end else state_nxt = S_PSHR;
      end
      S_PSHR: begin
        we = 1'b1; wa = IW'(k_r); wst = rd_st; wsz = rd_sz;
        k_nxt = k_r - 1'b1; state_nxt = S_SHRD;
      end
      S_RMRD: begin
        ra_a = IW'(k_r + 1'b1);
        if (k_r + 1'b1 >= count_r) begin
          count_nxt = count_r - 1'b1; state_nxt = S_PLW;
        end else state_nxt = S_RMV;
      end
      S_RMV: begin
        we = 1'b1; wa = IW'(k_r); wst = rd_st; wsz = rd_sz;
        k_nxt = k_r + 1'b1; state_nxt = S_RMRD;
      end
      S_PLW: begin
        if (alloc_r) begin
          brk_nxt = grow_end[16:0];
          hascur_nxt = 1'b0; k_nxt = cur_r; state_nxt = S_PWR;
        end else state_nxt = S_DONE;
      end
      S_PWR: begin
        ra_a = IW'(k_r);
        state_nxt = S_PRD2;
      end
      S_PRD2: begin
        best_nxt = k_r; bsz_nxt = rd_sz; bst_nxt = rd_st; hasb_nxt = 1'b1;
        state_nxt = S_SEVAL;
      end
      S_SRD: begin
        ra_a = IW'(k_r); k_nxt = k_r + 1'b1; state_nxt = S_SRCH;
      end
      S_SRCH: begin
        if (cand_ok && cand_better) begin
          best_nxt = k_r - 1'b1; bsz_nxt = rd_sz; bst_nxt = rd_st; hasb_nxt = 1'b1;
        end
        if (k_r < count_r) begin
          ra_a = IW'(k_r); k_nxt = k_r + 1'b1;
        end else state_nxt = S_SEVAL;
      end
      S_SEVAL: begin
        logic [17:0] need;
        need = {1'b0, arg_actual} + 18'(MIN_SPLIT_BYTES);
        if (!hasb_r) begin
          state_nxt = S_DONE;
          if (grow_end > 18'(HEAP_BYTES)) status_nxt = ST_OOM;
          else begin
            st_nxt = brk_r[15:0]; sz_nxt = 17'(CHUNK_BYTES);
            p_nxt = '0; k_nxt = '0; state_nxt = S_PRD;
          end
        end else if (bsz_r == arg_actual) begin
          addr_nxt = bst_r + 16'(HEADER_BYTES);
          k_nxt = best_r; alloc_nxt = 1'b0; state_nxt = S_RMRD;
          status_nxt = ST_OK;
        end else if ({1'b0, bsz_r} >= need) begin
          we = 1'b1; wa = IW'(best_r); wst = bst_r; wsz = bsz_r - arg_actual;
          addr_nxt = 16'(17'(bst_r) + (bsz_r - arg_actual) + 17'(HEADER_BYTES));
          state_nxt = S_DONE;
        end else begin
          cur_nxt = best_r; csz_nxt = bsz_r; cst_nxt = bst_r; hascur_nxt = 1'b1;
          hasb_nxt = 1'b0; k_nxt = '0; state_nxt = S_SRD;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; brk_r <= '0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; brk_r <= brk_nxt;
    end
    p_r <= p_nxt; k_r <= k_nxt; st_r <= st_nxt; sz_r <= sz_nxt;
    lst_r <= lst_nxt; lsz_r <= lsz_nxt; alloc_r <= alloc_nxt;
    cur_r <= cur_nxt; csz_r <= csz_nxt; cst_r <= cst_nxt; hascur_r <= hascur_nxt;
    best_r <= best_nxt; bsz_r <= bsz_nxt; bst_r <= bst_nxt; hasb_r <= hasb_nxt;
    status_r <= status_nxt; addr_r <= addr_nxt;
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = (state_r == S_DONE) ||
                     (state_r == S_PLW && !alloc_r && addr_r != '0) ;
  assign stat.status = status_r;
  assign addr = addr_r;
endmodule

### src/flha_ctrl.sv
// Request controller: decodes a beat, issues at most one datapath command, holds the result beat.
// Depends on flha_pkg.
module flha_ctrl #(
  parameter int HEADER_BYTES = 32,
  parameter int CHUNK_BYTES  = 8192
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [48:0]          in_data,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [17:0]          out_data,
  output flha_pkg::flha_cmd_t  cmd,
  output logic [15:0]          arg_start,
  output logic [16:0]          arg_size,
  output logic [16:0]          arg_actual,
  input  flha_pkg::flha_stat_t stat,
  input  logic [15:0]          addr
);
  import flha_pkg::*;
  localparam logic [1:0] C_IDLE = 2'd0, C_WAIT = 2'd1, C_OUT = 2'd2;
  logic [1:0]  state_r, state_nxt;
  logic [17:0] res_r, res_nxt;
  logic [15:0] as_r, as_nxt;
  logic [16:0] sz_r, sz_nxt, ac_r, ac_nxt;
  logic        act;
  logic [15:0] req, raddr, bb;
  logic [17:0] actual;
  assign act = in_data[0];
  assign req = in_data[16:1];
  assign raddr = in_data[32:17];
  assign bb = in_data[48:33];
  assign actual = {2'b0, req} + 18'(HEADER_BYTES);

  always_comb begin
    state_nxt = state_r; res_nxt = res_r; as_nxt = as_r; sz_nxt = sz_r; ac_nxt = ac_r;
    cmd.go = 1'b0; cmd.cmd = CMD_NONE;
    in_tready = (state_r == C_IDLE);
    unique case (state_r)
      C_IDLE: begin
        if (in_tvalid) begin
          as_nxt = raddr - 16'(HEADER_BYTES); sz_nxt = {1'b0, bb}; ac_nxt = actual[16:0];
          if (act) begin
            if (raddr == '0) begin
              res_nxt = {16'h0, ST_OK}; state_nxt = C_OUT;
            end else begin
              cmd.go = 1'b1; cmd.cmd = CMD_PLACE; state_nxt = C_WAIT;
            end
          end else if (req == '0) begin
            res_nxt = {16'h0, ST_OK}; state_nxt = C_OUT;
          end else if (actual > 18'(CHUNK_BYTES)) begin
            res_nxt = {16'h0, ST_BIG}; state_nxt = C_OUT;
          end else begin
            cmd.go = 1'b1; cmd.cmd = CMD_ALLOC; state_nxt = C_WAIT;
          end
        end
      end
      C_WAIT: begin
        if (stat.done) begin
          res_nxt = {(stat.status == ST_OK) ? addr : 16'h0, stat.status};
          state_nxt = C_OUT;
        end
      end
      C_OUT: if (out_tready && !stat.busy) state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= C_IDLE;
    else state_r <= state_nxt;
    res_r <= res_nxt; as_r <= as_nxt; sz_r <= sz_nxt; ac_r <= ac_nxt;
  end

  always_comb begin
    arg_start = (state_r == C_IDLE) ? as_nxt : as_r;
    arg_size = (state_r == C_IDLE) ? sz_nxt : sz_r;
    arg_actual = (state_r == C_IDLE) ? ac_nxt : ac_r;
  end
  assign out_tvalid = (state_r == C_OUT) && !stat.busy;
  assign out_data = res_r;
endmodule

### src/free_list_heap_allocator_unit.sv
// Free-list heap allocator top level: controller plus free table datapath.
// Depends on flha_pkg, flha_ctrl and flha_datapath.
//
// Input beat: action, request_bytes, release_addr, block_bytes. Each beat gives
// one result beat: status and payload_addr. One beat is in work at a time.
// An allocate walks the free table in size order: each search pass reads every
// entry once; a place sweep scans one entry per cycle and moves an entry with a
// read state and a write state (S_SHRD, then S_PSHR). An allocate runs one
// search pass per block it skips, so up to about FREE_SLOTS passes, plus a place
// sweep for each chunk it grows. The table memory has one read and one write port.
// Reset empties the table and the heap at once; no clearing pass.
// The result beat holds while out_tready is low; no new beat is taken then.
module free_list_heap_allocator_unit #(
  parameter int HEAP_BYTES      = 65536,
  parameter int CHUNK_BYTES     = 8192,
  parameter int HEADER_BYTES    = 32,
  parameter int MIN_SPLIT_BYTES = 40,
  parameter int FREE_SLOTS      = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // action, request_bytes, release_addr, block_bytes
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // status, payload_addr
);
  import flha_pkg::*;
  flha_cmd_t  cmd;
  flha_stat_t stat;
  logic [15:0] arg_start, addr;
  logic [16:0] arg_size, arg_actual;
  logic [17:0] res;

  flha_ctrl #(.HEADER_BYTES(HEADER_BYTES), .CHUNK_BYTES(CHUNK_BYTES)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_data(in_tdata[48:0]),
    .out_tvalid, .out_tready, .out_data(res), .cmd, .arg_start, .arg_size,
    .arg_actual, .stat, .addr
  );

  flha_datapath #(.HEAP_BYTES(HEAP_BYTES), .CHUNK_BYTES(CHUNK_BYTES),
    .HEADER_BYTES(HEADER_BYTES), .MIN_SPLIT_BYTES(MIN_SPLIT_BYTES),
    .FREE_SLOTS(FREE_SLOTS)) u_dp (
    .clk, .rst_n, .cmd, .arg_start, .arg_size, .arg_actual, .stat, .addr
  );

  assign out_tdata = {6'b0, res};

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !in_tready) else $error("beat taken while busy");
  a_err_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] != ST_OK) |-> out_tdata[17:2] == 16'h0)
    else $error("error result with address");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped");
endmodule
